// ----- rtl/urcpd_pkg.sv -----
// shared types, constants and helpers for the udp receive check and port demux
package urcpd_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PTR_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [15:0] AUTO_PORT_BASE  = 16'd1024;
  localparam logic [15:0] AUTO_PORT_RESET = 16'd1023;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_OPEN  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_LEN_UNDER = 3'd2;
  localparam logic [2:0] ST_LEN_OVER  = 3'd3;
  localparam logic [2:0] ST_CHECKSUM  = 3'd4;
  localparam logic [2:0] ST_NO_LISTEN = 3'd5;
  localparam logic [2:0] ST_PORT_BUSY = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] pseudo_sum;
    logic [7:0]  family;
    logic [31:0] address;
    logic [15:0] port;
    logic        promiscuous;
    logic [2:0]  handle;
  } udp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [15:0] src_port;
    logic [15:0] dest_port;
    logic [15:0] payload_len;
    logic [15:0] bound_port;
  } udp_out_t;

  typedef struct packed {
    logic [7:0]  family;
    logic [31:0] address;
    logic [15:0] port;
    logic [15:0] age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // ones' complement add with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- rtl/udp_receive_check_and_port_demux.sv -----
// top level: udp receive checks and listener table with port demultiplexing
//
// Commands enter on start while busy is low. Packet bytes are taken one per
// cycle with busy staying low; the byte marked last gives a verdict in the
// next cycle for a length or checksum fault, otherwise busy rises while the
// listener table is swept from its ram, one entry per cycle, and the result
// appears once the sweep is complete. An open with a given port sweeps the
// table once to check the port; an open with port zero sweeps once per
// candidate port tried; a promiscuous open and a full table give their result
// in the next cycle, and a close gives no result at all. The result
// strobe done is high for exactly one cycle and cannot be held off, so the
// receiver must take every transfer as it appears. The table contents sit in
// a single ram; only the per-entry valid flags are flip-flops.
module udp_receive_check_and_port_demux (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  urcpd_pkg::udp_in_t  cmd,
  output logic              done,
  output urcpd_pkg::udp_out_t rsp
);
  import urcpd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_AUTO, S_CHECK} state_t;
  state_t state;

  // listener table
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [15:0] open_sequence;
  logic [15:0] next_try_port;

  // packet assembly
  logic [15:0] byte_count;
  logic [15:0] header_words [4];
  logic [15:0] sum_acc;
  logic [7:0]  odd_hold;

  // captured packet for the sweep
  logic [7:0]  pk_family;
  logic [31:0] pk_address;
  logic [15:0] pk_sport;
  logic [15:0] pk_dport;
  logic [15:0] pk_ulen;

  // sweep control
  logic [PTR_W-1:0] rd_ptr;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  logic [15:0]      best_dist;
  logic             in_use;
  logic             auto_mode;
  logic [15:0]      cand_port;
  logic [IDX_W-1:0] op_slot;

  // ram
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  urcpd_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign busy = (state != S_IDLE);

  // byte path: next packet state for an accepted byte
  logic [15:0] hw_next [4];
  logic [15:0] sum_next;
  logic [7:0]  odd_next;
  logic [15:0] count_next;
  logic [15:0] acc_base;
  logic [15:0] chk_sum;
  logic [2:0]  pk_status;

  always_comb begin
    hw_next = header_words;
    if (byte_count < 16'd8) begin
      if (byte_count[0]) begin
        hw_next[byte_count[2:1]][7:0] = cmd.data_byte;
      end else begin
        hw_next[byte_count[2:1]][15:8] = cmd.data_byte;
      end
    end
    acc_base = (byte_count == 16'd0) ? cmd.pseudo_sum : sum_acc;
    sum_next = acc_base;
    odd_next = odd_hold;
    if (byte_count < 16'd6 || byte_count < hw_next[2]) begin
      if (byte_count[0]) begin
        sum_next = fold_add(acc_base, {odd_hold, cmd.data_byte});
      end else begin
        odd_next = cmd.data_byte;
      end
    end
    count_next = (byte_count == 16'hFFFF) ? byte_count : byte_count + 16'd1;
    chk_sum = hw_next[2][0] ? fold_add(sum_next, {odd_next, 8'h00}) : sum_next;
    priority if (count_next < 16'd8) begin
      pk_status = ST_SHORT;
    end else if (hw_next[2] < 16'd8) begin
      pk_status = ST_LEN_UNDER;
    end else if (hw_next[2] > count_next) begin
      pk_status = ST_LEN_OVER;
    end else if (hw_next[3] != 16'd0 && chk_sum != 16'hFFFF) begin
      pk_status = ST_CHECKSUM;
    end else begin
      pk_status = ST_OK;
    end
  end

  // lowest free slot
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // compare stage on the entry read out of the ram
  logic        cmp_hit;
  logic        cmp_better;
  logic [15:0] cmp_dist;
  logic        cmp_port_hit;
  logic        cmp_last;

  always_comb begin
    cmp_hit = rd_vld && entry_valid[rd_idx]
              && (rd_entry.family == pk_family || rd_entry.family == 8'd0)
              && (rd_entry.port == pk_dport || rd_entry.port == 16'd0)
              && (rd_entry.address == pk_address || rd_entry.address == 32'd0);
    cmp_dist   = open_sequence - rd_entry.age;
    cmp_better = cmp_hit && (!found || cmp_dist < best_dist);
    cmp_port_hit = rd_vld && entry_valid[rd_idx] && rd_entry.port == cand_port;
    cmp_last   = rd_vld && (rd_idx == IDX_W'(TABLE_ENTRIES - 1));
  end

  // table writes: promiscuous open at once, checked open at end of sweep
  logic promisc_wr;
  logic check_wr;

  assign promisc_wr = (state == S_IDLE) && start && cmd.action == ACT_OPEN
                      && free_found && cmd.promiscuous;
  assign check_wr   = (state == S_CHECK) && cmp_last && !(in_use || cmp_port_hit);

  always_comb begin
    ram_we    = promisc_wr || check_wr;
    ram_waddr = promisc_wr ? free_idx : op_slot;
    ram_wdata.family  = promisc_wr ? 8'd0  : pk_family;
    ram_wdata.address = promisc_wr ? 32'd0 : pk_address;
    ram_wdata.port    = promisc_wr ? 16'd0 : cand_port;
    ram_wdata.age     = open_sequence;
  end

  // report slot in three bits, wrapping for larger tables
  logic [IDX_W+2:0] slot_wide_best;
  logic [IDX_W+2:0] slot_wide_op;
  logic [IDX_W+2:0] slot_wide_free;
  assign slot_wide_best = {3'b000, (cmp_better ? rd_idx : best_idx)};
  assign slot_wide_op   = {3'b000, op_slot};
  assign slot_wide_free = {3'b000, free_idx};

  logic [15:0] auto_next;
  assign auto_next = next_try_port + 16'd1;

  logic [6:0] handle_wide;
  assign handle_wide = {4'd0, cmd.handle};
  logic [IDX_W+2:0] handle_idx_wide;
  assign handle_idx_wide = {{IDX_W{1'b0}}, cmd.handle};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_valid   <= '0;
      open_sequence <= '0;
      next_try_port <= AUTO_PORT_RESET;
      byte_count    <= '0;
      for (int i = 0; i < 4; i++) begin
        header_words[i] <= '0;
      end
      sum_acc   <= '0;
      odd_hold  <= '0;
      done      <= 1'b0;
      rd_ptr    <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      in_use    <= 1'b0;
      auto_mode <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          rd_ptr <= '0;
          rd_vld <= 1'b0;
          found  <= 1'b0;
          in_use <= 1'b0;
          if (start) begin
            priority case (cmd.action)
              ACT_BYTE: begin
                if (cmd.last) begin
                  // packet ends: state cleared for the next buffer
                  byte_count <= '0;
                  for (int i = 0; i < 4; i++) begin
                    header_words[i] <= '0;
                  end
                  sum_acc  <= '0;
                  odd_hold <= '0;
                  if (pk_status != ST_OK) begin
                    done <= 1'b1;
                    rsp  <= '{status: pk_status, default: '0};
                  end else begin
                    pk_family  <= cmd.family;
                    pk_address <= cmd.address;
                    pk_sport   <= hw_next[0];
                    pk_dport   <= hw_next[1];
                    pk_ulen    <= hw_next[2];
                    state      <= S_SCAN;
                  end
                end else begin
                  byte_count   <= count_next;
                  header_words <= hw_next;
                  sum_acc      <= sum_next;
                  odd_hold     <= odd_next;
                end
              end
              ACT_OPEN: begin
                op_slot    <= free_idx;
                pk_family  <= cmd.family;
                pk_address <= cmd.address;
                if (!free_found) begin
                  done <= 1'b1;
                  rsp  <= '{status: ST_FULL, default: '0};
                end else if (cmd.promiscuous) begin
                  entry_valid[free_idx] <= 1'b1;
                  open_sequence <= open_sequence + 16'd1;
                  done <= 1'b1;
                  rsp  <= '{status: ST_OK, slot: slot_wide_free[2:0], default: '0};
                end else if (cmd.port != 16'd0) begin
                  cand_port <= cmd.port;
                  auto_mode <= 1'b0;
                  state     <= S_CHECK;
                end else begin
                  auto_mode <= 1'b1;
                  state     <= S_AUTO;
                end
              end
              ACT_CLOSE: begin
                if (handle_wide < 7'(TABLE_ENTRIES)) begin
                  entry_valid[handle_idx_wide[IDX_W-1:0]] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          // issue one ram read per cycle, compare in the following cycle
          if (rd_ptr < PTR_W'(TABLE_ENTRIES)) begin
            rd_ptr <= rd_ptr + PTR_W'(1);
          end
          rd_vld <= (rd_ptr < PTR_W'(TABLE_ENTRIES));
          rd_idx <= rd_ptr[IDX_W-1:0];
          if (cmp_better) begin
            found     <= 1'b1;
            best_idx  <= rd_idx;
            best_dist <= cmp_dist;
          end
          if (cmp_last) begin
            done <= 1'b1;
            rsp.status      <= (found || cmp_better) ? ST_OK : ST_NO_LISTEN;
            rsp.slot        <= (found || cmp_better) ? slot_wide_best[2:0] : 3'd0;
            rsp.src_port    <= pk_sport;
            rsp.dest_port   <= pk_dport;
            rsp.payload_len <= pk_ulen - 16'd8;
            rsp.bound_port  <= '0;
            state <= S_IDLE;
          end
        end

        S_AUTO: begin
          // next candidate port; counter that has wrapped fails for good
          rd_ptr <= '0;
          rd_vld <= 1'b0;
          in_use <= 1'b0;
          if (next_try_port == 16'd0) begin
            done <= 1'b1;
            rsp  <= '{status: ST_PORT_BUSY, default: '0};
            state <= S_IDLE;
          end else begin
            next_try_port <= auto_next;
            if (auto_next >= AUTO_PORT_BASE) begin
              cand_port <= auto_next;
              state     <= S_CHECK;
            end
          end
        end

        S_CHECK: begin
          if (rd_ptr < PTR_W'(TABLE_ENTRIES)) begin
            rd_ptr <= rd_ptr + PTR_W'(1);
          end
          rd_vld <= (rd_ptr < PTR_W'(TABLE_ENTRIES));
          rd_idx <= rd_ptr[IDX_W-1:0];
          in_use <= in_use || cmp_port_hit;
          if (cmp_last) begin
            if (in_use || cmp_port_hit) begin
              if (auto_mode) begin
                state <= S_AUTO;
              end else begin
                done <= 1'b1;
                rsp  <= '{status: ST_PORT_BUSY, default: '0};
                state <= S_IDLE;
              end
            end else begin
              entry_valid[op_slot] <= 1'b1;
              open_sequence <= open_sequence + 16'd1;
              done <= 1'b1;
              rsp  <= '{status: ST_OK, slot: slot_wide_op[2:0], bound_port: cand_port,
                        default: '0};
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- rtl/urcpd_ram.sv -----
// generic single write port ram with registered read
module urcpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/urcpd_checker.sv -----
// port-level checker for the udp receive check and port demux, with its bind
module urcpd_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input urcpd_pkg::udp_in_t  cmd,
  input logic                done,
  input urcpd_pkg::udp_out_t rsp
);
  import urcpd_pkg::*;

  logic acc;
  assign acc = start && !busy;

  // a close never gives a result transfer
  a_close_silent: assert property (@(posedge clk) disable iff (rst)
    acc && cmd.action == ACT_CLOSE |=> !done)
    else $error("close produced a result");

  // a byte that is not last gives no result
  a_mid_byte_silent: assert property (@(posedge clk) disable iff (rst)
    acc && cmd.action == ACT_BYTE && !cmd.last |=> !done)
    else $error("result on a middle byte");

  // the last byte either reports at once or starts the table sweep
  a_last_byte_progress: assert property (@(posedge clk) disable iff (rst)
    acc && cmd.action == ACT_BYTE && cmd.last |=> done || busy)
    else $error("last byte left no trace");

  // failed opens report no slot and no port
  a_open_fail_clean: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status == ST_PORT_BUSY || rsp.status == ST_FULL)
    |-> rsp.slot == 3'd0 && rsp.bound_port == 16'd0)
    else $error("failed open carries slot or port");

endmodule

bind udp_receive_check_and_port_demux urcpd_checker u_urcpd_checker (.*);
